// ===== rtl/tsc_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Tracking speed controller package
// Shared widths, register map, sequencer states and a saturation helper function.
// ----------------------------------------------------------------------------
package tsc_pkg;

  localparam int HISTORY_DEPTH_DEF = 8;
  localparam int POS_WIDTH_DEF     = 16;

  localparam int IN_POS_W  = 16;
  localparam int TICK_W    = 20;
  localparam int CFG_W     = 16;
  localparam int LIMIT_W   = 15;
  localparam int SPEED_W   = 10;
  localparam int LIM_W     = SPEED_W - 1;
  localparam int OUT_MAX   = (1 << LIM_W) - 1;
  localparam int ONE_PIXEL = 16;

  localparam int ERR_W        = 32;
  localparam int MUL_A_W      = ERR_W + 1;
  localparam int MUL_B_W      = CFG_W + 1;
  localparam int PROD_W       = MUL_A_W + MUL_B_W;
  localparam int CENTER_SHIFT = 12;
  localparam int ROUND_SHIFT  = 16;
  localparam int ROUND_HALF   = 1 << (ROUND_SHIFT - 1);
  localparam int OBJ_SHIFT    = 9;
  localparam int OBJ_FACTOR   = 31250;
  localparam int DIVIDEND_W   = 56;
  localparam int ACC_W        = DIVIDEND_W + 2;
  localparam int MAG_W        = ACC_W - ROUND_SHIFT;

  localparam int APB_DATA_W = 32;
  localparam int APB_ADDR_W = 4;

  localparam logic [CFG_W-1:0]   SCALE_X_RST = 16'd986;
  localparam logic [CFG_W-1:0]   SCALE_Y_RST = 16'd986;
  localparam logic [CFG_W-1:0]   GAIN_RST    = 16'd13107;
  localparam logic [LIMIT_W-1:0] LIMIT_RST   = 15'd400;

  typedef enum logic [1:0] {
    REG_SCALE_X,
    REG_SCALE_Y,
    REG_GAIN,
    REG_LIMIT
  } reg_idx_t;

  typedef struct packed {
    logic [CFG_W-1:0]   scale_x;
    logic [CFG_W-1:0]   scale_y;
    logic [CFG_W-1:0]   gain;
    logic [LIMIT_W-1:0] limit;
  } cfg_t;

  typedef struct packed {
    logic busy;
    logic done;
  } div_status_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_UPD,
    S_MX,
    S_MY,
    S_EY,
    S_CG,
    S_CD,
    S_DV,
    S_DW,
    S_SUM,
    S_RND,
    S_LIM,
    S_DONE
  } state_t;

  function automatic logic signed [ERR_W-1:0] sat_err(input logic signed [PROD_W-1:0] v);
    logic fits;
    fits = (&v[PROD_W-1:ERR_W-1]) || (~|v[PROD_W-1:ERR_W-1]);
    if (fits) begin
      return $signed(v[ERR_W-1:0]);
    end else if (v[PROD_W-1]) begin
      return $signed({1'b1, {(ERR_W-1){1'b0}}});
    end else begin
      return $signed({1'b0, {(ERR_W-1){1'b1}}});
    end
  endfunction

endpackage

// ===== rtl/tsc_stream_if.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Tracking speed controller channels
// Valid/ready channels for tick items and speed results.
// ----------------------------------------------------------------------------
interface tsc_in_if import tsc_pkg::*; ();
  logic                valid;
  logic                ready;
  logic [IN_POS_W-1:0] pos_x;
  logic [IN_POS_W-1:0] pos_y;
  logic [TICK_W-1:0]   tick_us;
  logic                restart;
  logic                manual;

  modport source(output valid, pos_x, pos_y, tick_us, restart, manual, input ready);
  modport sink(input valid, pos_x, pos_y, tick_us, restart, manual, output ready);
endinterface

interface tsc_out_if import tsc_pkg::*; ();
  logic                      valid;
  logic                      ready;
  logic signed [SPEED_W-1:0] azm_speed;
  logic signed [SPEED_W-1:0] alt_speed;
  logic                      drive_valid;

  modport source(output valid, azm_speed, alt_speed, drive_valid, input ready);
  modport sink(input valid, azm_speed, alt_speed, drive_valid, output ready);
endinterface

// ===== rtl/tsc_cfg_regs.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Tracking speed controller configuration registers
// APB-style register file holding image scales, gain and speed limit.
// ----------------------------------------------------------------------------
module tsc_cfg_regs import tsc_pkg::*; (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  psel,
  input  logic                  penable,
  input  logic                  pwrite,
  input  logic [APB_ADDR_W-1:0] paddr,
  input  logic [APB_DATA_W-1:0] pwdata,
  output logic [APB_DATA_W-1:0] prdata,
  output logic                  pready,
  output cfg_t                  cfg
);

  cfg_t     cfg_r;
  reg_idx_t idx;
  logic     wr_en;

  assign idx    = reg_idx_t'(paddr[APB_ADDR_W-1:2]);
  assign wr_en  = psel && penable && pwrite;
  assign pready = 1'b1;
  assign cfg    = cfg_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.scale_x <= SCALE_X_RST;
      cfg_r.scale_y <= SCALE_Y_RST;
      cfg_r.gain    <= GAIN_RST;
      cfg_r.limit   <= LIMIT_RST;
    end else if (wr_en) begin
      unique case (idx)
        REG_SCALE_X: cfg_r.scale_x <= pwdata[CFG_W-1:0];
        REG_SCALE_Y: cfg_r.scale_y <= pwdata[CFG_W-1:0];
        REG_GAIN:    cfg_r.gain    <= pwdata[CFG_W-1:0];
        REG_LIMIT:   cfg_r.limit   <= pwdata[LIMIT_W-1:0];
        default:     cfg_r         <= cfg_r;
      endcase
    end
  end

  always_comb begin
    unique case (idx)
      REG_SCALE_X: prdata = APB_DATA_W'(cfg_r.scale_x);
      REG_SCALE_Y: prdata = APB_DATA_W'(cfg_r.scale_y);
      REG_GAIN:    prdata = APB_DATA_W'(cfg_r.gain);
      REG_LIMIT:   prdata = APB_DATA_W'(cfg_r.limit);
      default:     prdata = '0;
    endcase
  end

endmodule

// ===== rtl/tsc_mul.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Tracking speed controller shared multiplier
// Signed multiplier with a registered product, shared by all scaling steps.
// ----------------------------------------------------------------------------
module tsc_mul import tsc_pkg::*; (
  input  logic                      clk,
  input  logic signed [MUL_A_W-1:0] mul_a,
  input  logic signed [MUL_B_W-1:0] mul_b,
  output logic signed [PROD_W-1:0]  prod_r
);

  always_ff @(posedge clk) begin
    prod_r <= PROD_W'(mul_a) * PROD_W'(mul_b);
  end

endmodule

// ===== rtl/tsc_div.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Tracking speed controller divider
// Unsigned restoring divider that retires two quotient bits per cycle.
// ----------------------------------------------------------------------------
module tsc_div import tsc_pkg::*; #(
  parameter int DIVISOR_W = TICK_W + 3
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  start,
  input  logic [DIVIDEND_W-1:0] dividend,
  input  logic [DIVISOR_W-1:0]  divisor,
  output div_status_t           status,
  output logic [DIVIDEND_W-1:0] quotient
);

  localparam int STEPS = DIVIDEND_W / 2;
  localparam int CNT_W = $clog2(STEPS + 1);

  logic                  busy_r;
  logic                  done_r;
  logic [CNT_W-1:0]      cnt_r;
  logic [DIVISOR_W-1:0]  rem_r;
  logic [DIVISOR_W-1:0]  rem_nxt;
  logic [DIVIDEND_W-1:0] quo_r;
  logic [DIVIDEND_W-1:0] quo_nxt;
  logic [DIVISOR_W-1:0]  dsr_r;

  always_comb begin
    logic [DIVISOR_W:0]    trial;
    logic [DIVISOR_W-1:0]  rem;
    logic [DIVIDEND_W-1:0] q;
    rem = rem_r;
    q   = quo_r;
    for (int i = 0; i < 2; i++) begin
      trial = {rem, q[DIVIDEND_W-1]};
      q     = {q[DIVIDEND_W-2:0], 1'b0};
      if (trial >= {1'b0, dsr_r}) begin
        rem  = DIVISOR_W'(trial - {1'b0, dsr_r});
        q[0] = 1'b1;
      end else begin
        rem = trial[DIVISOR_W-1:0];
      end
    end
    rem_nxt = rem;
    quo_nxt = q;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= CNT_W'(STEPS);
      end else if (busy_r) begin
        cnt_r <= cnt_r - CNT_W'(1);
        if (cnt_r == CNT_W'(1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      rem_r <= '0;
      quo_r <= dividend;
      dsr_r <= divisor;
    end else if (busy_r) begin
      rem_r <= rem_nxt;
      quo_r <= quo_nxt;
    end
  end

  assign status.busy = busy_r;
  assign status.done = done_r;
  assign quotient    = quo_r;

endmodule

// ===== rtl/tsc_core.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Tracking speed controller core
// Sequencer, tracking state and histories around the shared multiplier and
// divider, with the registered result stage.
// ----------------------------------------------------------------------------
module tsc_core import tsc_pkg::*; #(
  parameter int HISTORY_DEPTH = HISTORY_DEPTH_DEF,
  parameter int POS_WIDTH     = POS_WIDTH_DEF
) (
  input  logic      clk,
  input  logic      rst_n,
  input  cfg_t      cfg,
  tsc_in_if.sink    in_chan,
  tsc_out_if.source out_chan
);

  localparam int TSW    = TICK_W + $clog2(HISTORY_DEPTH);
  localparam int PIW    = (POS_WIDTH < IN_POS_W) ? POS_WIDTH : IN_POS_W;
  localparam int DIFF_W = POS_WIDTH + 1;
  localparam logic signed [PROD_W-1:0] CEN_BIAS = PROD_W'((1 << CENTER_SHIFT) - 1);

  state_t state_r, state_nxt;
  logic   axis_r;
  logic   started_r;

  logic [POS_WIDTH-1:0] pos_x_r, pos_y_r;
  logic [TICK_W-1:0]    tick_r;
  logic                 restart_r, manual_r;

  logic [POS_WIDTH-1:0] sp_x_r, sp_y_r, lp_x_r, lp_y_r;
  logic signed [ERR_W-1:0] eh_x_r [HISTORY_DEPTH];
  logic signed [ERR_W-1:0] eh_y_r [HISTORY_DEPTH];
  logic [TICK_W-1:0]    th_r [HISTORY_DEPTH];
  logic [TSW-1:0]       tsum_r;

  logic signed [DIFF_W-1:0]  diff_x_r, diff_y_r;
  logic signed [MUL_A_W-1:0] delta_r;
  logic signed [ACC_W-1:0]   acc_r;
  logic                      neg_r;
  logic [MAG_W-1:0]          rmag_r;
  logic                      rneg_r;
  logic signed [SPEED_W-1:0] res_azm_r, res_alt_r;
  logic                      res_drv_r;

  logic                      out_valid_r;
  logic signed [SPEED_W-1:0] out_azm_r, out_alt_r;
  logic                      out_drv_r;

  logic signed [MUL_A_W-1:0] mul_a;
  logic signed [MUL_B_W-1:0] mul_b;
  logic signed [PROD_W-1:0]  prod_r;

  logic                  div_start;
  logic [DIVIDEND_W-1:0] div_dividend;
  logic [DIVIDEND_W-1:0] div_q;
  div_status_t           div_status;

  logic                    accept;
  logic                    out_load;
  logic                    lost;
  logic [POS_WIDTH-1:0]    pe_x, pe_y, spn_x, spn_y;
  logic signed [DIFF_W-1:0] diff_x, diff_y;
  logic signed [ERR_W-1:0] err0, errl;
  logic signed [PROD_W-1:0] cen;
  logic [PROD_W-1:0]       pmag;
  logic signed [ACC_W-1:0] q_ext;
  logic [ACC_W-1:0]        rsum;
  logic [LIM_W-1:0]        lim;
  logic [LIM_W-1:0]        mag9;
  logic signed [SPEED_W-1:0] spd;
  logic signed [SPEED_W-1:0] lim_s;

  tsc_mul u_mul (
    .clk    (clk),
    .mul_a  (mul_a),
    .mul_b  (mul_b),
    .prod_r (prod_r)
  );

  tsc_div #(.DIVISOR_W(TSW)) u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_start),
    .dividend (div_dividend),
    .divisor  (tsum_r),
    .status   (div_status),
    .quotient (div_q)
  );

  assign in_chan.ready = (state_r == S_IDLE);
  assign accept        = in_chan.valid && in_chan.ready;
  assign out_load      = (state_r == S_DONE) && (!out_valid_r || out_chan.ready);

  assign lost  = (pos_x_r < POS_WIDTH'(ONE_PIXEL)) && (pos_y_r < POS_WIDTH'(ONE_PIXEL));
  assign pe_x  = lost ? lp_x_r : pos_x_r;
  assign pe_y  = lost ? lp_y_r : pos_y_r;
  assign spn_x = manual_r ? pe_x : sp_x_r;
  assign spn_y = manual_r ? pe_y : sp_y_r;
  assign diff_x = $signed({1'b0, pe_x}) - $signed({1'b0, spn_x});
  assign diff_y = $signed({1'b0, pe_y}) - $signed({1'b0, spn_y});

  assign err0 = axis_r ? eh_y_r[0] : eh_x_r[0];
  assign errl = axis_r ? eh_y_r[HISTORY_DEPTH-1] : eh_x_r[HISTORY_DEPTH-1];

  assign cen  = prod_r[PROD_W-1] ? ((prod_r + CEN_BIAS) >>> CENTER_SHIFT)
                                 : (prod_r >>> CENTER_SHIFT);
  assign pmag = prod_r[PROD_W-1] ? (PROD_W'(0) - prod_r) : prod_r;
  assign div_dividend = {pmag[DIVIDEND_W-OBJ_SHIFT-1:0], {OBJ_SHIFT{1'b0}}};
  assign q_ext = $signed(ACC_W'(div_q));
  assign rsum  = acc_r[ACC_W-1] ? (ACC_W'(ROUND_HALF) - acc_r) : (acc_r + ACC_W'(ROUND_HALF));

  assign lim   = (cfg.limit > LIMIT_W'(OUT_MAX)) ? LIM_W'(OUT_MAX) : cfg.limit[LIM_W-1:0];
  assign lim_s = $signed({1'b0, lim});
  assign mag9  = (rmag_r > MAG_W'(lim)) ? lim : rmag_r[LIM_W-1:0];
  assign spd   = rneg_r ? $signed(SPEED_W'(0) - {1'b0, mag9}) : $signed({1'b0, mag9});

  always_comb begin
    state_nxt = state_r;
    mul_a     = '0;
    mul_b     = '0;
    div_start = 1'b0;
    unique case (state_r)
      S_IDLE: begin
        if (accept) begin
          state_nxt = S_UPD;
        end
      end
      S_UPD: begin
        if (restart_r || !started_r) begin
          state_nxt = S_DONE;
        end else begin
          state_nxt = S_MX;
        end
      end
      S_MX: begin
        mul_a     = MUL_A_W'(diff_x_r);
        mul_b     = $signed({1'b0, cfg.scale_x});
        state_nxt = S_MY;
      end
      S_MY: begin
        mul_a     = MUL_A_W'(diff_y_r);
        mul_b     = $signed({1'b0, cfg.scale_y});
        state_nxt = S_EY;
      end
      S_EY: begin
        state_nxt = manual_r ? S_DONE : S_CG;
      end
      S_CG: begin
        mul_a     = MUL_A_W'(err0);
        mul_b     = $signed({1'b0, cfg.gain});
        state_nxt = S_CD;
      end
      S_CD: begin
        mul_a     = delta_r;
        mul_b     = $signed(MUL_B_W'(OBJ_FACTOR));
        state_nxt = S_DV;
      end
      S_DV: begin
        if (tsum_r == '0) begin
          state_nxt = S_RND;
        end else begin
          div_start = 1'b1;
          state_nxt = S_DW;
        end
      end
      S_DW: begin
        if (div_status.done) begin
          state_nxt = S_SUM;
        end
      end
      S_SUM: state_nxt = S_RND;
      S_RND: state_nxt = S_LIM;
      S_LIM: state_nxt = axis_r ? S_DONE : S_CG;
      S_DONE: begin
        if (out_load) begin
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      axis_r      <= 1'b0;
      started_r   <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (state_r == S_UPD && restart_r) begin
        started_r <= 1'b1;
      end
      if (state_r == S_EY) begin
        axis_r <= 1'b0;
      end else if (state_r == S_LIM) begin
        axis_r <= 1'b1;
      end
      if (out_load) begin
        out_valid_r <= 1'b1;
      end else if (out_chan.ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      pos_x_r   <= POS_WIDTH'(in_chan.pos_x[PIW-1:0]);
      pos_y_r   <= POS_WIDTH'(in_chan.pos_y[PIW-1:0]);
      tick_r    <= in_chan.tick_us;
      restart_r <= in_chan.restart;
      manual_r  <= in_chan.manual;
    end

    unique case (state_r)
      S_UPD: begin
        res_azm_r <= '0;
        res_alt_r <= '0;
        res_drv_r <= 1'b0;
        if (restart_r) begin
          sp_x_r <= pos_x_r;
          sp_y_r <= pos_y_r;
          lp_x_r <= pos_x_r;
          lp_y_r <= pos_y_r;
          for (int k = 0; k < HISTORY_DEPTH; k++) begin
            eh_x_r[k] <= '0;
            eh_y_r[k] <= '0;
            th_r[k]   <= tick_r;
          end
          tsum_r <= TSW'(tick_r) * TSW'(HISTORY_DEPTH);
        end else if (started_r) begin
          lp_x_r   <= pe_x;
          lp_y_r   <= pe_y;
          sp_x_r   <= spn_x;
          sp_y_r   <= spn_y;
          diff_x_r <= diff_x;
          diff_y_r <= diff_y;
          for (int k = HISTORY_DEPTH - 1; k > 0; k--) begin
            th_r[k] <= th_r[k-1];
          end
          th_r[0] <= tick_r;
          tsum_r  <= tsum_r - TSW'(th_r[HISTORY_DEPTH-1]) + TSW'(tick_r);
        end
      end
      S_MY: begin
        for (int k = HISTORY_DEPTH - 1; k > 0; k--) begin
          eh_x_r[k] <= eh_x_r[k-1];
        end
        eh_x_r[0] <= sat_err(prod_r);
      end
      S_EY: begin
        for (int k = HISTORY_DEPTH - 1; k > 0; k--) begin
          eh_y_r[k] <= eh_y_r[k-1];
        end
        eh_y_r[0] <= sat_err(prod_r);
      end
      S_CG: begin
        delta_r <= MUL_A_W'(err0) - MUL_A_W'(errl);
      end
      S_CD: begin
        acc_r <= ACC_W'(cen);
      end
      S_DV: begin
        neg_r <= prod_r[PROD_W-1];
      end
      S_SUM: begin
        acc_r <= neg_r ? (acc_r - q_ext) : (acc_r + q_ext);
      end
      S_RND: begin
        rmag_r <= rsum[ACC_W-1:ROUND_SHIFT];
        rneg_r <= acc_r[ACC_W-1] ^ axis_r;
      end
      S_LIM: begin
        if (axis_r) begin
          res_alt_r <= spd;
          res_drv_r <= 1'b1;
        end else begin
          res_azm_r <= spd;
        end
      end
      default: begin
      end
    endcase

    if (out_load) begin
      out_azm_r <= res_azm_r;
      out_alt_r <= res_alt_r;
      out_drv_r <= res_drv_r;
    end
  end

  assign out_chan.valid       = out_valid_r;
  assign out_chan.azm_speed   = out_azm_r;
  assign out_chan.alt_speed   = out_alt_r;
  assign out_chan.drive_valid = out_drv_r;

  a_speed_in_limit: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && out_drv_r |-> (out_azm_r <= lim_s) && (out_azm_r >= -lim_s) &&
                                 (out_alt_r <= lim_s) && (out_alt_r >= -lim_s))
    else $error("speed result beyond the configured limit");

  a_idle_speed_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && !out_drv_r |-> (out_azm_r == '0) && (out_alt_r == '0))
    else $error("nonzero speed without drive");

  a_no_drive_before_start: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && !started_r |-> !out_drv_r)
    else $error("drive given before the first restart");

  a_div_owned: assert property (@(posedge clk) disable iff (!rst_n)
    div_status.busy |-> (state_r == S_DW))
    else $error("divider running outside its wait state");

endmodule

// ===== rtl/tracking_speed_controller_top.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Tracking speed controller
// A normal tick runs the gain step and one division in the shared radix-4 divider
// for each axis, the division skipped while the tick sum is zero. A manual tick
// stops after the error histories; a restart tick, or a tick before the first
// restart, goes straight to the result. One tick is in work at a time; the next
// transfer is taken in the cycle after the result is stored.
// Synchronous active-low reset restores register defaults and waits for restart.
// ----------------------------------------------------------------------------
module tracking_speed_controller_top import tsc_pkg::*; #(
  parameter int HISTORY_DEPTH = HISTORY_DEPTH_DEF,
  parameter int POS_WIDTH     = POS_WIDTH_DEF
) (
  input  logic                  clk,
  input  logic                  rst_n,
  tsc_in_if.sink                in_chan,
  tsc_out_if.source             out_chan,
  input  logic                  psel,
  input  logic                  penable,
  input  logic                  pwrite,
  input  logic [APB_ADDR_W-1:0] paddr,
  input  logic [APB_DATA_W-1:0] pwdata,
  output logic [APB_DATA_W-1:0] prdata,
  output logic                  pready
);

  cfg_t cfg;

  tsc_cfg_regs u_cfg (
    .clk     (clk),
    .rst_n   (rst_n),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  tsc_core #(
    .HISTORY_DEPTH (HISTORY_DEPTH),
    .POS_WIDTH     (POS_WIDTH)
  ) u_core (
    .clk      (clk),
    .rst_n    (rst_n),
    .cfg      (cfg),
    .in_chan  (in_chan),
    .out_chan (out_chan)
  );

endmodule
